// File: rtl/rxfd_pkg.sv
// Shared types and constants for the run-length font decoder with XOR base.
package rxfd_pkg;

    // Image size in bytes and the width of the position counter (0 .. IMAGE_BYTES).
    localparam int IMAGE_BYTES = 2048;
    localparam int POS_W       = $clog2(IMAGE_BYTES + 1);

    // Base font store geometry, split into an even and an odd bank.
    localparam int ADDR_W     = 11;
    localparam int BASE_DEPTH = 2048;
    localparam int BANK_AW    = ADDR_W - 1;
    localparam int BANK_DEPTH = BASE_DEPTH / 2;

    // Run length handling.
    localparam int LEN_W   = 8;
    localparam int RUN_MAX = 128;
    localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int POSX_W  = (POS_W > ADDR_W) ? POS_W : ADDR_W;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CODE  = 2'd2
    } t_op;

    // Front-end sequencer state.
    typedef enum logic {
        ST_ITEM,
        ST_RUN
    } t_state;

    // One result pair as it moves through the pipeline.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        raw;
        logic [1:0]        cnt;
        logic              last;
        logic              done;
    } t_pair;

endpackage

// File: rtl/rxfd_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface rxfd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  data;
    logic [10:0] base_addr;

    modport source (output valid, output op, output data, output base_addr, input ready);
    modport sink   (input valid, input op, input data, input base_addr, output ready);
endinterface

interface rxfd_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] out_addr;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [1:0]  byte_count;
    logic        run_last;
    logic        image_done;

    modport source (output valid, output out_addr, output byte_first, output byte_second,
                    output byte_count, output run_last, output image_done, input ready);
    modport sink   (input valid, input out_addr, input byte_first, input byte_second,
                    input byte_count, input run_last, input image_done, output ready);
endinterface

interface rxfd_cfg_if;
    logic valid;
    logic ready;
    logic xor_enable;

    modport source (output valid, output xor_enable, input ready);
    modport sink   (input valid, input xor_enable, output ready);
endinterface

// File: rtl/rxfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rxfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; the read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rle_xor_font_decoder_unit.sv
// Top level of the run-length font decoder with XOR base font.
//
// Usage: items enter on i_in (op, data, base_addr) as valid/ready transactions.
// A start item clears the image position and the remembered last byte; a load
// item writes one base font byte; a code item is a literal or a run. Results
// leave on o_out, each holding one or two decoded bytes. The single register
// xor_enable is written through i_cfg, which is always ready.
// After the transaction that causes it, a result passes the base RAM read
// stage and then the output register before it appears on o_out.
// Start, load and literal items do not hold the input; a run holds it until
// its last result pair has been made. The base store is banked into even and
// odd RAMs so that the two bytes of a pair are read in the same cycle.
// Reset (synchronous, active low) clears the position, the last byte, the
// register and the pipeline; the base store keeps whatever it held and needs
// no clearing pass. When the receiver stalls, the output register holds its
// result, one more pair waits in the read stage, and then the input stalls.
module rle_xor_font_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rxfd_in_if.sink       i_in,
    rxfd_cfg_if.sink      i_cfg,
    rxfd_out_if.source    o_out
);

    rxfd_pkg::t_state r_state, n_state;

    logic [rxfd_pkg::POS_W-1:0]  r_pos;
    logic [7:0]                  r_last;
    logic [rxfd_pkg::LEN_W-1:0]  r_run_left;
    logic                        r_xor;
    logic                        r_s1_valid;
    rxfd_pkg::t_pair             r_s1;
    logic                        r_o_valid;
    rxfd_pkg::t_pair             r_o;
    logic [7:0]                  r_o_first;
    logic [7:0]                  r_o_second;

    logic                        w_accept;
    logic                        w_adv;
    logic                        w_s1_move;
    logic                        w_full;
    logic                        w_lit;
    logic                        w_run_in;
    logic                        w_gen;
    logic [rxfd_pkg::POS_W-1:0]  w_room;
    logic [rxfd_pkg::LEN_W-1:0]  w_len_in;
    logic [rxfd_pkg::LEN_W-1:0]  w_len_cap;
    logic [rxfd_pkg::LEN_W-1:0]  w_len;
    logic [rxfd_pkg::LEN_W-1:0]  w_left;
    logic [1:0]                  w_cnt;
    logic [7:0]                  w_byte;
    logic [rxfd_pkg::POS_W:0]    w_sum;
    logic [rxfd_pkg::POSX_W-1:0] w_pos_x;
    logic [rxfd_pkg::ADDR_W-1:0] w_addr;
    rxfd_pkg::t_pair             w_pair;

    logic                         w_we_even, w_we_odd;
    logic [rxfd_pkg::BANK_AW-1:0] w_rd_even, w_rd_odd;
    logic [7:0]                   w_q_even, w_q_odd;
    logic [7:0]                   w_base0, w_base1;

    // Pipeline movement: the read stage moves when the output register frees up.
    assign w_s1_move = r_s1_valid && (!r_o_valid || o_out.ready);
    assign w_adv     = !r_s1_valid || w_s1_move;
    assign w_accept  = i_in.valid && i_in.ready;

    // Decode of the accepted item.
    always_comb begin
        w_full   = r_pos >= rxfd_pkg::POS_W'(rxfd_pkg::IMAGE_BYTES);
        w_lit    = w_accept && (i_in.op == rxfd_pkg::OP_CODE) && !w_full && !i_in.data[7];
        w_run_in = w_accept && (i_in.op == rxfd_pkg::OP_CODE) && !w_full && i_in.data[7];
        w_room   = rxfd_pkg::POS_W'(rxfd_pkg::IMAGE_BYTES) - r_pos;
        w_len_in = (i_in.data[6:0] == 7'd0) ? rxfd_pkg::LEN_W'(rxfd_pkg::RUN_MAX)
                                            : {1'b0, i_in.data[6:0]};
        if (rxfd_pkg::CMP_W'(w_len_in) > rxfd_pkg::CMP_W'(w_room)) begin
            w_len_cap = rxfd_pkg::LEN_W'(w_room);
        end else begin
            w_len_cap = w_len_in;
        end
    end

    // Current pair: taken from the pending run or from the accepted item.
    always_comb begin
        if (r_state == rxfd_pkg::ST_RUN) begin
            w_gen  = w_adv;
            w_len  = r_run_left;
            w_byte = r_last;
        end else begin
            w_gen  = w_lit || w_run_in;
            w_len  = w_lit ? rxfd_pkg::LEN_W'(1) : w_len_cap;
            w_byte = w_lit ? i_in.data : r_last;
        end
        w_cnt   = (w_len >= rxfd_pkg::LEN_W'(2)) ? 2'd2 : 2'd1;
        w_left  = w_len - rxfd_pkg::LEN_W'(w_cnt);
        w_sum   = {1'b0, r_pos} + (rxfd_pkg::POS_W + 1)'(w_cnt);
        w_pos_x = rxfd_pkg::POSX_W'(r_pos);
        w_addr  = w_pos_x[rxfd_pkg::ADDR_W-1:0];
        w_pair.addr = w_addr;
        w_pair.raw  = w_byte;
        w_pair.cnt  = w_cnt;
        w_pair.last = (w_left == '0);
        w_pair.done = w_sum >= (rxfd_pkg::POS_W + 1)'(rxfd_pkg::IMAGE_BYTES);
    end

    // Next state of the run sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rxfd_pkg::ST_ITEM: begin
                if (w_gen && (w_left != '0)) begin
                    n_state = rxfd_pkg::ST_RUN;
                end
            end
            rxfd_pkg::ST_RUN: begin
                if (w_gen && (w_left == '0)) begin
                    n_state = rxfd_pkg::ST_ITEM;
                end
            end
            default: n_state = rxfd_pkg::ST_ITEM;
        endcase
    end

    // Sequencer outputs: the input is taken only between runs with room in the pipeline.
    always_comb begin
        case (r_state)
            rxfd_pkg::ST_ITEM: i_in.ready = w_adv;
            rxfd_pkg::ST_RUN:  i_in.ready = 1'b0;
            default:           i_in.ready = 1'b0;
        endcase
    end

    assign i_cfg.ready = 1'b1;

    // Base store banks: even positions in one RAM, odd in the other.
    assign w_we_even = w_accept && (i_in.op == rxfd_pkg::OP_LOAD) && !i_in.base_addr[0];
    assign w_we_odd  = w_accept && (i_in.op == rxfd_pkg::OP_LOAD) && i_in.base_addr[0];
    assign w_rd_odd  = w_addr[rxfd_pkg::ADDR_W-1:1];
    assign w_rd_even = w_addr[0] ? (w_addr[rxfd_pkg::ADDR_W-1:1] + rxfd_pkg::BANK_AW'(1))
                                 : w_addr[rxfd_pkg::ADDR_W-1:1];

    rxfd_ram #(
        .WIDTH (8),
        .DEPTH (rxfd_pkg::BANK_DEPTH)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (w_we_even),
        .i_waddr (i_in.base_addr[rxfd_pkg::ADDR_W-1:1]),
        .i_wdata (i_in.data),
        .i_re    (w_gen),
        .i_raddr (w_rd_even),
        .o_rdata (w_q_even)
    );

    rxfd_ram #(
        .WIDTH (8),
        .DEPTH (rxfd_pkg::BANK_DEPTH)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (w_we_odd),
        .i_waddr (i_in.base_addr[rxfd_pkg::ADDR_W-1:1]),
        .i_wdata (i_in.data),
        .i_re    (w_gen),
        .i_raddr (w_rd_odd),
        .o_rdata (w_q_odd)
    );

    // Base bytes for the first and second position of the pair in the read stage; zero while XOR is off.
    always_comb begin
        w_base0 = r_s1.addr[0] ? w_q_odd : w_q_even;
        w_base1 = r_s1.addr[0] ? w_q_even : w_q_odd;
        if (!r_xor) begin
            w_base0 = 8'd0;
            w_base1 = 8'd0;
        end
    end

    // Control state: sequencer, position, last byte, register and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rxfd_pkg::ST_ITEM;
            r_pos      <= '0;
            r_last     <= 8'd0;
            r_xor      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_xor <= i_cfg.xor_enable;
            end
            if (w_accept && (i_in.op == rxfd_pkg::OP_START)) begin
                r_pos  <= '0;
                r_last <= 8'd0;
            end else if (w_gen) begin
                r_pos <= w_sum[rxfd_pkg::POS_W-1:0];
                if (w_lit) begin
                    r_last <= i_in.data;
                end
            end
            if (w_gen) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the run counter, the read stage and the output.
    always_ff @(posedge i_clk) begin
        if (w_gen) begin
            r_run_left <= w_left;
            r_s1       <= w_pair;
        end
        if (w_s1_move) begin
            r_o        <= r_s1;
            r_o_first  <= r_s1.raw ^ w_base0;
            r_o_second <= (r_s1.cnt == 2'd2) ? (r_s1.raw ^ w_base1) : 8'd0;
        end
    end

    // Result channel.
    assign o_out.valid       = r_o_valid;
    assign o_out.out_addr    = r_o.addr;
    assign o_out.byte_first  = r_o_first;
    assign o_out.byte_second = r_o_second;
    assign o_out.byte_count  = r_o.cnt;
    assign o_out.run_last    = r_o.last;
    assign o_out.image_done  = r_o.done;

endmodule
